[rtl/assert_macros.svh]
// assertion macros shared by the session slot allocator rtl
// no dependencies; included by the modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge of clk, off while rst_n is low
`define SSA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every rising edge of clk, also during reset
`define SSA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/ssa_pkg.sv]
// shared types and constants of the session slot allocator
// no dependencies; imported by every module of the block
package ssa_pkg;

    localparam int SLOTS_DEFAULT = 8;

    localparam int DEV_W   = 16;
    localparam int STAMP_W = 32;
    localparam int LIMIT_W = 8;
    localparam int FUNC_W  = 3;
    localparam int SLOT_W  = 3;
    localparam int HOW_W   = 3;

    localparam logic [LIMIT_W-1:0] AGE_LIMIT_RESET = 8'd4;

    localparam logic [FUNC_W-1:0] FUNC_ACQUIRE = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_SET_TX  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLR_TX  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_SET_RX  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CLR_RX  = 3'd4;

    localparam logic [HOW_W-1:0] HOW_MATCH = 3'd0;
    localparam logic [HOW_W-1:0] HOW_EMPTY = 3'd1;
    localparam logic [HOW_W-1:0] HOW_IDLE  = 3'd2;
    localparam logic [HOW_W-1:0] HOW_AGED  = 3'd3;
    localparam logic [HOW_W-1:0] HOW_NONE  = 3'd4;
    localparam logic [HOW_W-1:0] HOW_FLAG  = 3'd5;

    // write command into the slot table
    typedef struct packed {
        logic             claim;
        logic             set_tx;
        logic             clr_tx;
        logic             set_rx;
        logic             clr_rx;
        logic [DEV_W-1:0] owner;
    } tbl_cmd_t;

    // outcome of the parallel search passes
    typedef struct packed {
        logic match_hit;
        logic empty_hit;
        logic idle_hit;
        logic empty_rx;
        logic empty_tx;
    } tbl_find_t;

    // one entry looked up by index
    typedef struct packed {
        logic occupied;
        logic tx;
        logic rx;
    } tbl_entry_t;

endpackage

[rtl/ssa_stamp_ram.sv]
// age stamp memory, one 32-bit stamp per slot, registered read
// depends on ssa_pkg
module ssa_stamp_ram #(
    parameter int SLOTS = ssa_pkg::SLOTS_DEFAULT
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0]  waddr,
    input  logic [ssa_pkg::STAMP_W-1:0]                 wdata,
    input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0]  raddr,
    output logic [ssa_pkg::STAMP_W-1:0]                 rdata
);
    import ssa_pkg::*;

    logic [STAMP_W-1:0] mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

[rtl/ssa_slot_table.sv]
// slot table: owner ids and held flags, with the match, empty and idle searches
// depends on ssa_pkg and assert_macros.svh
module ssa_slot_table #(
    parameter int SLOTS = ssa_pkg::SLOTS_DEFAULT
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic [ssa_pkg::DEV_W-1:0]                   dev,
    input  ssa_pkg::tbl_cmd_t                           cmd,
    input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0]  cmd_idx,
    input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0]  q_idx,
    output ssa_pkg::tbl_find_t                          find,
    output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0]  match_idx,
    output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0]  empty_idx,
    output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0]  idle_idx,
    output ssa_pkg::tbl_entry_t                         q
);
    import ssa_pkg::*;

    localparam int IDX_W = SLOTS > 1 ? $clog2(SLOTS) : 1;

    logic [DEV_W-1:0] owner_reg [SLOTS];
    logic [SLOTS-1:0] tx_reg;
    logic [SLOTS-1:0] rx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                owner_reg[i] <= '0;
            end
            tx_reg <= '0;
            rx_reg <= '0;
        end
        else
        begin
            if (cmd.claim)
            begin
                owner_reg[cmd_idx] <= cmd.owner;
            end
            if (cmd.set_tx)
            begin
                tx_reg[cmd_idx] <= 1'b1;
            end
            else if (cmd.clr_tx)
            begin
                tx_reg[cmd_idx] <= 1'b0;
            end
            if (cmd.set_rx)
            begin
                rx_reg[cmd_idx] <= 1'b1;
            end
            else if (cmd.clr_rx)
            begin
                rx_reg[cmd_idx] <= 1'b0;
            end
        end
    end

    // lowest index wins: scan from the top down so a lower hit overwrites a higher one
    always_comb
    begin
        find      = '0;
        match_idx = '0;
        empty_idx = '0;
        idle_idx  = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (owner_reg[i] == dev)
            begin
                find.match_hit = 1'b1;
                match_idx      = IDX_W'(i);
            end
            if (owner_reg[i] == '0)
            begin
                find.empty_hit = 1'b1;
                find.empty_rx  = rx_reg[i];
                find.empty_tx  = tx_reg[i];
                empty_idx      = IDX_W'(i);
            end
            if (owner_reg[i] != '0 && !rx_reg[i] && !tx_reg[i])
            begin
                find.idle_hit = 1'b1;
                idle_idx      = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        q.occupied = owner_reg[q_idx] != '0;
        q.tx       = tx_reg[q_idx];
        q.rx       = rx_reg[q_idx];
    end

    `include "assert_macros.svh"

    `SSA_ASSERT(a_claim_no_flag_set, (cmd.claim |-> !cmd.set_tx && !cmd.set_rx), "claim with flag set")
    `SSA_ASSERT(a_claim_lands, (cmd.claim |=> owner_reg[$past(cmd_idx)] == $past(cmd.owner)), "claimed owner not stored")
    `SSA_ASSERT(a_empty_is_free, (find.empty_hit |-> owner_reg[empty_idx] == '0), "empty search points at occupied slot")

endmodule

[rtl/session_slot_allocator_unit.sv]
// A flag update, or an acquire that finds a matching, empty or idle slot, is handled
// in two steps: the item is registered, then the slot table is searched in parallel
// and written back once the output register is free. An acquire that falls back to an
// aged slot then walks at most SLOTS age stamps, one a cycle while the output
// register is free. The next item is taken once the current one has put its
// result into the output register; a result waiting there does not block acceptance.
// Reset clears owners, flags and the age counter. A stamp is written whenever its slot
// is taken, before any scan can read it, so the stamp memory has no reset and no
// clearing pass. The age limit register may be written at any time the block is idle
// and is 4 after reset.
// depends on ssa_pkg, ssa_slot_table, ssa_stamp_ram and assert_macros.svh
module session_slot_allocator_unit #(
    parameter int SLOTS = ssa_pkg::SLOTS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [ssa_pkg::LIMIT_W-1:0]   cfg_wr_data,     // age_limit
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [23:0]                   s_axis_tdata,    // func, device_id, target_slot
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [15:0]                   m_axis_tdata     // granted, slot, how, drop_rx, drop_tx
);
    import ssa_pkg::*;

    localparam int IDX_W = SLOTS > 1 ? $clog2(SLOTS) : 1;

    typedef enum logic [1:0] {S_IDLE, S_DECIDE, S_SCAN} state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   chk_idx_reg, chk_idx_next;
    logic [FUNC_W-1:0]  func_reg;
    logic [DEV_W-1:0]   dev_reg;
    logic [SLOT_W-1:0]  tgt_reg;
    logic [STAMP_W-1:0] age_counter_reg;
    logic [LIMIT_W-1:0] age_limit_reg;

    logic               out_valid_reg;
    logic               granted_reg, granted_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [HOW_W-1:0]   how_reg, how_next;
    logic               drop_rx_reg, drop_rx_next;
    logic               drop_tx_reg, drop_tx_next;

    logic               s_acc;
    logic               out_free;
    logic               out_load;
    logic               tgt_ok;
    logic               aged_ok;
    logic [STAMP_W-1:0] age_diff;

    tbl_cmd_t           cmd;
    logic [IDX_W-1:0]   cmd_idx;
    tbl_find_t          find;
    logic [IDX_W-1:0]   match_idx, empty_idx, idle_idx;
    tbl_entry_t         q;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [IDX_W-1:0]   ram_raddr;
    logic [STAMP_W-1:0] stamp_rd;

    ssa_slot_table #(.SLOTS(SLOTS)) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .dev       (dev_reg),
        .cmd       (cmd),
        .cmd_idx   (cmd_idx),
        .q_idx     (chk_idx_reg),
        .find      (find),
        .match_idx (match_idx),
        .empty_idx (empty_idx),
        .idle_idx  (idle_idx),
        .q         (q)
    );

    ssa_stamp_ram #(.SLOTS(SLOTS)) u_stamps (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (age_counter_reg),
        .raddr (ram_raddr),
        .rdata (stamp_rd)
    );

    assign s_axis_tready = state_reg == S_IDLE;
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, drop_tx_reg, drop_rx_reg, how_reg, slot_reg, granted_reg};

    assign tgt_ok   = 32'(tgt_reg) < SLOTS;
    assign age_diff = age_counter_reg - stamp_rd;
    assign aged_ok  = q.occupied && !q.tx && (age_diff >= STAMP_W'(age_limit_reg));

    always_comb
    begin
        state_next   = state_reg;
        chk_idx_next = chk_idx_reg;
        out_load     = 1'b0;
        granted_next = 1'b0;
        slot_next    = '0;
        how_next     = HOW_NONE;
        drop_rx_next = 1'b0;
        drop_tx_next = 1'b0;
        cmd          = '0;
        cmd.owner    = dev_reg;
        cmd_idx      = '0;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_raddr    = chk_idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_acc)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                    case (func_reg)
                        FUNC_ACQUIRE:
                        begin
                            granted_next = 1'b1;
                            if (find.match_hit)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = match_idx;
                                slot_next = SLOT_W'(match_idx);
                                how_next  = HOW_MATCH;
                            end
                            else if (find.empty_hit)
                            begin
                                cmd.claim    = 1'b1;
                                cmd.clr_tx   = 1'b1;
                                cmd.clr_rx   = 1'b1;
                                cmd_idx      = empty_idx;
                                ram_we       = 1'b1;
                                ram_waddr    = empty_idx;
                                slot_next    = SLOT_W'(empty_idx);
                                how_next     = HOW_EMPTY;
                                drop_rx_next = find.empty_rx;
                                drop_tx_next = find.empty_tx;
                            end
                            else if (find.idle_hit)
                            begin
                                cmd.claim = 1'b1;
                                cmd_idx   = idle_idx;
                                ram_we    = 1'b1;
                                ram_waddr = idle_idx;
                                slot_next = SLOT_W'(idle_idx);
                                how_next  = HOW_IDLE;
                            end
                            else
                            begin
                                out_load     = 1'b0;
                                granted_next = 1'b0;
                                state_next   = S_SCAN;
                                chk_idx_next = '0;
                                ram_raddr    = '0;
                            end
                        end
                        FUNC_SET_TX, FUNC_CLR_TX, FUNC_SET_RX, FUNC_CLR_RX:
                        begin
                            if (tgt_ok)
                            begin
                                cmd.set_tx   = func_reg == FUNC_SET_TX;
                                cmd.clr_tx   = func_reg == FUNC_CLR_TX;
                                cmd.set_rx   = func_reg == FUNC_SET_RX;
                                cmd.clr_rx   = func_reg == FUNC_CLR_RX;
                                cmd_idx      = IDX_W'(tgt_reg);
                                granted_next = 1'b1;
                                slot_next    = tgt_reg;
                                how_next     = HOW_FLAG;
                            end
                        end
                        default:
                        begin
                            how_next = HOW_NONE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (out_free)
                begin
                    if (aged_ok)
                    begin
                        cmd.claim    = 1'b1;
                        cmd.clr_rx   = 1'b1;
                        cmd_idx      = chk_idx_reg;
                        ram_we       = 1'b1;
                        ram_waddr    = chk_idx_reg;
                        out_load     = 1'b1;
                        granted_next = 1'b1;
                        slot_next    = SLOT_W'(chk_idx_reg);
                        how_next     = HOW_AGED;
                        drop_rx_next = q.rx;
                        state_next   = S_IDLE;
                    end
                    else if (chk_idx_reg == IDX_W'(SLOTS - 1))
                    begin
                        out_load   = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        chk_idx_next = chk_idx_reg + 1'b1;
                        ram_raddr    = chk_idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            chk_idx_reg     <= '0;
            age_counter_reg <= '0;
            age_limit_reg   <= AGE_LIMIT_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            chk_idx_reg <= chk_idx_next;
            if (cfg_wr_en)
            begin
                age_limit_reg <= cfg_wr_data;
            end
            if (s_acc && s_axis_tdata[2:0] == FUNC_ACQUIRE)
            begin
                age_counter_reg <= age_counter_reg + 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            func_reg <= s_axis_tdata[2:0];
            dev_reg  <= s_axis_tdata[18:3];
            tgt_reg  <= s_axis_tdata[21:19];
        end
        if (out_load)
        begin
            granted_reg <= granted_next;
            slot_reg    <= slot_next;
            how_reg     <= how_next;
            drop_rx_reg <= drop_rx_next;
            drop_tx_reg <= drop_tx_next;
        end
    end

    `include "assert_macros.svh"

    `SSA_ASSERT(a_accept_then_decide, (s_acc |=> state_reg == S_DECIDE), "accepted item not decided next")
    `SSA_ASSERT(a_load_from_work, (out_load |-> state_reg == S_DECIDE || state_reg == S_SCAN), "result loaded while idle")
    `SSA_ASSERT(a_counter_on_acquire, (!$stable(age_counter_reg) |-> $past(s_acc && s_axis_tdata[2:0] == FUNC_ACQUIRE)), "age counter moved without acquire")
    `SSA_ASSERT(a_scan_in_range, (state_reg == S_SCAN |-> 32'(chk_idx_reg) < SLOTS), "scan index beyond table")

endmodule
